// ----- hw/rtl/pcl_pkg.sv -----
// Package for the positional byte list: capacity default, command and
// status codes, sequencer state type. No dependencies.
package pcl_pkg;

    // Default number of stored bytes
    localparam int PCL_CAPACITY = 16;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_REM_FRONT = 3'd3;
    localparam logic [2:0] CMD_REM_BACK  = 3'd4;
    localparam logic [2:0] CMD_REM_POS   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SHIFT,
        S_PUT,
        S_SHIFT_R,
        S_RESP
    } t_state;

endpackage

// ----- hw/rtl/pcl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/positional_char_list_core.sv -----
// Positional byte list: circular buffer in one RAM with head and count,
// shifting entries one per cycle for positional insert and remove.
// Depends on pcl_pkg and pcl_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | i_valid / o_ready  | i_command, i_position, i_data_in
//  output   | o_valid / i_ready  | o_data_out, o_status, o_item_count,
//           |                    | o_is_empty
//
// Rejected commands and inserts at front or back go from idle straight to the
// response; removals first read the addressed byte; positional commands also
// shift the stored bytes between the position and the end, moving one per cycle through the RAM.
// Reset clears head, count, sequencer and output valid; RAM contents are
// left as is. A new transaction is taken whenever the sequencer is idle,
// even while a result waits at the output; the next result waits for it.
module positional_char_list_core
    import pcl_pkg::*;
#(
    parameter int CAPACITY = PCL_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_command,
    input  logic [4:0] i_position,
    input  logic [7:0] i_data_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_out,
    output logic [1:0] o_status,
    output logic [4:0] o_item_count,
    output logic       o_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 2;
    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    // Logical slot to physical RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    // Sequencer and list state
    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wr, n_wr;
    logic [7:0]    r_din, n_din;
    logic [7:0]    r_res_data, n_res_data;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data, n_out_data;
    logic [1:0]    r_out_status, n_out_status;
    logic [4:0]    r_out_count, n_out_count;
    logic          r_out_empty, n_out_empty;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Decode of the incoming command
    logic          accept;
    logic          is_ins, is_rem;
    logic          full, empty;
    logic [XW-1:0] pos_x, cnt_x;
    logic [CW-1:0] ins_idx, rem_idx, pos_idx;
    logic [1:0]    dec_status;
    logic          ins_front, ins_back;
    logic          out_free, resp_load;
    logic          rd_front, rd_back, sh_last, shr_last;
    logic [CW+4:0] cnt_ext;

    pcl_ram #(
        .WIDTH(8),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Command decode and range checks
    always_comb begin
        is_ins  = (i_command inside {CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS});
        is_rem  = (i_command inside {CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_POS});
        full    = (r_count == CW'(CAPACITY));
        empty   = (r_count == '0);
        pos_x   = XW'(i_position);
        cnt_x   = XW'(r_count);
        pos_idx = CW'(pos_x - XW'(1));

        case (i_command)
            CMD_INS_FRONT: ins_idx = '0;
            CMD_INS_BACK:  ins_idx = r_count;
            default:       ins_idx = pos_idx;
        endcase
        case (i_command)
            CMD_REM_FRONT: rem_idx = '0;
            CMD_REM_BACK:  rem_idx = r_count - CW'(1);
            default:       rem_idx = pos_idx;
        endcase

        dec_status = ST_OK;
        if (is_ins) begin
            if (full) begin
                dec_status = ST_FULL;
            end else if (i_command == CMD_INS_POS &&
                         (pos_x == '0 || pos_x > cnt_x + XW'(1))) begin
                dec_status = ST_RANGE;
            end
        end else if (is_rem) begin
            if (empty) begin
                dec_status = ST_EMPTY;
            end else if (i_command == CMD_REM_POS && (pos_x == '0 || pos_x > cnt_x)) begin
                dec_status = ST_RANGE;
            end
        end else begin
            dec_status = ST_RANGE;
        end

        ins_front = (ins_idx == '0);
        ins_back  = (ins_idx == r_count);
        resp_load = (r_state == S_RESP) && out_free;
        rd_front  = (r_idx == '0);
        rd_back   = (r_idx + CW'(1) == r_count);
        sh_last   = (r_wr == r_idx + CW'(1));
        shr_last  = (r_wr + CW'(2) == r_count);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (dec_status != ST_OK) begin
                        n_state = S_RESP;
                    end else if (is_rem) begin
                        n_state = S_RD;
                    end else if (ins_front || ins_back) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_RD: begin
                if (rd_front || rd_back) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SHIFT_R;
                end
            end
            S_SHIFT: begin
                if (sh_last) begin
                    n_state = S_PUT;
                end
            end
            S_PUT:     n_state = S_RESP;
            S_SHIFT_R: begin
                if (shr_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        n_wr         = r_wr;
        n_din        = r_din;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = phys(r_head, r_wr);
        ram_wdata    = ram_rdata;
        ram_raddr    = phys(r_head, r_count - CW'(1));

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_din        = i_data_in;
                    n_res_data   = '0;
                    n_res_status = dec_status;
                    n_idx        = is_rem ? rem_idx : ins_idx;
                    n_wr         = r_count;
                    if (is_rem) begin
                        ram_raddr = phys(r_head, rem_idx);
                    end
                    if (dec_status == ST_OK && is_ins) begin
                        if (ins_front) begin
                            // new head one slot below the old one
                            n_head    = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
                            ram_we    = 1'b1;
                            ram_waddr = n_head;
                            ram_wdata = i_data_in;
                            n_count   = r_count + CW'(1);
                        end else if (ins_back) begin
                            ram_we    = 1'b1;
                            ram_waddr = phys(r_head, r_count);
                            ram_wdata = i_data_in;
                            n_count   = r_count + CW'(1);
                        end
                    end
                end
            end
            S_RD: begin
                n_res_data = ram_rdata;
                if (rd_front) begin
                    n_head  = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
                    n_count = r_count - CW'(1);
                end else if (rd_back) begin
                    n_count = r_count - CW'(1);
                end else begin
                    ram_raddr = phys(r_head, r_idx + CW'(1));
                    n_wr      = r_idx;
                end
            end
            S_SHIFT: begin
                // move slot wr-1 up into slot wr, walking down
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_wr);
                ram_wdata = ram_rdata;
                if (!sh_last) begin
                    ram_raddr = phys(r_head, r_wr - CW'(2));
                    n_wr      = r_wr - CW'(1);
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_idx);
                ram_wdata = r_din;
                n_count   = r_count + CW'(1);
            end
            S_SHIFT_R: begin
                // move slot wr+1 down into slot wr, walking up
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_wr);
                ram_wdata = ram_rdata;
                if (shr_last) begin
                    n_count = r_count - CW'(1);
                end else begin
                    ram_raddr = phys(r_head, r_wr + CW'(2));
                    n_wr      = r_wr + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_comb begin
        cnt_ext      = {5'b0, r_count};
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        if (resp_load) begin
            n_out_valid  = 1'b1;
            n_out_data   = r_res_data;
            n_out_status = r_res_status;
            n_out_count  = cnt_ext[4:0];
            n_out_empty  = (r_count == '0);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_wr         <= n_wr;
        r_din        <= n_din;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
    end

    assign o_valid      = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_status     = r_out_status;
    assign o_item_count = r_out_count;
    assign o_is_empty   = r_out_empty;

`ifndef SYNTH
    // count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count beyond capacity");

    // insert shift cursor stays between target slot and old count
    a_shift_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_wr > r_idx && r_wr <= r_count))
        else $error("insert shift cursor out of range");

    // remove shift cursor stays below the last occupied slot
    a_shift_r_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_R) |-> (r_wr >= r_idx && r_wr + CW'(1) < r_count))
        else $error("remove shift cursor out of range");

    // every accepted transaction takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after accept");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for positional_char_list_core: directed and random
// insert/remove transactions checked against a byte-queue predictor.
// Depends on pcl_pkg and the positional_char_list_core RTL.
module testbench;
    import pcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 400;
    localparam int          TAIL_ITEMS   = 60;
    localparam int          PAUSE_ITEM   = 200;
    localparam int          HOLDOFF_AT   = 150;
    localparam int          HOLDOFF_LEN  = 300;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 200000;
    // Codes outside the defined command set
    localparam logic [2:0]  CMD_SPARE_A  = 3'd6;
    localparam logic [2:0]  CMD_SPARE_B  = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic [4:0] count;
        logic       empty;
    } t_list_result;

    // Tracks the list contents and the results still owed by the block
    class list_scoreboard;
        logic [7:0]   contents[$];
        t_list_result owed_results[$];
        int           errors;

        function int depth();
            return contents.size();
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted command to the list and queue its result
        function void apply_command(logic [2:0] cmd, logic [4:0] pos, logic [7:0] din);
            t_list_result res;
            int           p;
            int           n;
            p = int'(pos);
            n = contents.size();
            res = '0;
            res.status = ST_OK;
            if (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK || cmd == CMD_INS_POS) begin
                if (n >= PCL_CAPACITY) begin
                    res.status = ST_FULL;
                end else if (cmd == CMD_INS_FRONT) begin
                    contents.push_front(din);
                end else if (cmd == CMD_INS_BACK) begin
                    contents.push_back(din);
                end else if (p == 0 || p > n + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    contents.insert(p - 1, din);
                end
            end else if (cmd == CMD_REM_FRONT || cmd == CMD_REM_BACK || cmd == CMD_REM_POS) begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else if (cmd == CMD_REM_FRONT) begin
                    res.data = contents.pop_front();
                end else if (cmd == CMD_REM_BACK) begin
                    res.data = contents.pop_back();
                end else if (p == 0 || p > n) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = contents[p - 1];
                    contents.delete(p - 1);
                end
            end else begin
                res.status = ST_RANGE;
            end
            res.count = 5'(contents.size());
            res.empty = (contents.size() == 0);
            owed_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Check one result transaction against the oldest owed result
        function void check_result(logic [7:0] dout, logic [1:0] st, logic [4:0] cnt,
                                   logic emp);
            t_list_result exp_r;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %0h status %0d",
                         $time, dout, st);
                errors++;
                return;
            end
            exp_r = owed_results.pop_front();
            compare_field("data_out", exp_r.data, dout);
            compare_field("status", {6'd0, exp_r.status}, {6'd0, st});
            compare_field("item_count", {3'd0, exp_r.count}, {3'd0, cnt});
            compare_field("is_empty", {7'd0, exp_r.empty}, {7'd0, emp});
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_command;
    logic [4:0] i_position;
    logic [7:0] i_data_in;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_data_out;
    logic [1:0] o_status;
    logic [4:0] o_item_count;
    logic       o_is_empty;

    list_scoreboard board = new();
    int  cycle_count  = 0;
    int  results_seen = 0;
    bit  quiet_tail   = 1'b0;
    int  fill_bias    = 1;   // 0 drain, 1 balanced, 2 fill

    positional_char_list_core #(
        .CAPACITY(PCL_CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_data_in   (i_data_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_item_count(o_item_count),
        .o_is_empty  (o_is_empty)
    );

    always #6 i_clk = ~i_clk;

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Reset held at start, released once
    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Offer one transaction, with an optional idle burst before it
    task automatic send_command(input logic [2:0] cmd, input logic [4:0] pos,
                                input logic [7:0] din);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_position <= pos;
        i_data_in  <= din;
        do @(posedge i_clk); while (!o_ready);
        board.apply_command(cmd, pos, din);
    endtask

    // Position mostly in range, with edges and wild values mixed in
    function automatic logic [4:0] pick_position(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 5'($urandom_range(1, (lim < 1) ? 1 : lim));
        if (r < 88) return 5'd0;
        if (r < 94) return 5'(lim + 1);
        return 5'($urandom_range(0, 31));
    endfunction

    // Random command; the bias drifts so the list swings between full and empty
    task automatic send_random();
        int         n;
        int         ins_pct;
        int         sel;
        logic [2:0] cmd;
        logic [4:0] pos;
        n = board.depth();
        if ($urandom_range(0, 19) == 0) fill_bias = $urandom_range(0, 2);
        ins_pct = (fill_bias == 0) ? 25 : (fill_bias == 1) ? 50 : 80;
        sel = $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 6) begin
            cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
            pos = 5'($urandom_range(0, 31));
        end else if ($urandom_range(0, 99) < ins_pct) begin
            cmd = (sel == 0) ? CMD_INS_FRONT : (sel == 1) ? CMD_INS_BACK : CMD_INS_POS;
            pos = (cmd == CMD_INS_POS) ? pick_position(n + 1) : 5'($urandom_range(0, 31));
        end else begin
            cmd = (sel == 0) ? CMD_REM_FRONT : (sel == 1) ? CMD_REM_BACK : CMD_REM_POS;
            pos = (cmd == CMD_REM_POS) ? pick_position(n) : 5'($urandom_range(0, 31));
        end
        send_command(cmd, pos, 8'($urandom_range(0, 255)));
    endtask

    // Stimulus
    initial begin
        int k;
        i_valid    <= 1'b0;
        i_command  <= CMD_INS_FRONT;
        i_position <= 5'd0;
        i_data_in  <= 8'd0;
        while (!i_rst_n) @(posedge i_clk);

        // Removals on an empty list, position checked only after emptiness
        send_command(CMD_REM_FRONT, 5'd0, 8'h11);
        send_command(CMD_REM_BACK, 5'd31, 8'h22);
        send_command(CMD_REM_POS, 5'd0, 8'h33);
        // Insert position bounds, data extremes and spare command codes
        send_command(CMD_INS_POS, 5'd0, 8'h44);
        send_command(CMD_INS_POS, 5'd1, 8'h00);
        send_command(CMD_INS_FRONT, 5'd31, 8'hFF);
        send_command(CMD_INS_POS, 5'd3, 8'hA5);
        send_command(CMD_INS_POS, 5'd31, 8'h5A);
        send_command(CMD_SPARE_A, 5'd5, 8'h77);
        send_command(CMD_SPARE_B, 5'd31, 8'hFF);
        // Remove position bounds with three bytes stored
        send_command(CMD_REM_POS, 5'd0, 8'h00);
        send_command(CMD_REM_POS, 5'd4, 8'h00);
        // Fill to capacity, then every insert is refused
        for (k = 0; k < 13; k++) begin
            send_command((k % 3 == 0) ? CMD_INS_FRONT : (k % 3 == 1) ? CMD_INS_BACK
                         : CMD_INS_POS, 5'((k % board.depth()) + 1),
                         8'($urandom_range(0, 255)));
        end
        send_command(CMD_INS_FRONT, 5'd1, 8'h01);
        send_command(CMD_INS_BACK, 5'd1, 8'h02);
        send_command(CMD_INS_POS, 5'd1, 8'h03);
        // Removal at the last position of a full list, then at both ends
        send_command(CMD_REM_POS, 5'd16, 8'h00);
        send_command(CMD_REM_BACK, 5'd0, 8'h00);
        send_command(CMD_REM_FRONT, 5'd0, 8'h00);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            if (k == PAUSE_ITEM) begin
                // Let the block drain completely before going on
                i_valid <= 1'b0;
                do @(posedge i_clk); while (board.pending() != 0);
            end
            send_random();
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: check each result transaction, stall in random bursts and one long hold-off
    initial begin
        int stall_left;
        bit held_off;
        stall_left = 0;
        held_off   = 1'b0;
        i_ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                board.check_result(o_data_out, o_status, o_item_count, o_is_empty);
                results_seen++;
            end
            if (!held_off && results_seen >= HOLDOFF_AT) begin
                // Long hold-off so the block backs up and stalls its input
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (stall_left > 0 && !quiet_tail) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_ram.sv
hw/rtl/positional_char_list_core.sv
dv/testbench.sv
